[src/rnnc_pkg.sv]
package rnnc_pkg;

	localparam int W_W        = 16;
	localparam int FRAC_W     = 12;
	localparam int PROD_W     = 2 * W_W;
	localparam int ACC_W      = 36;
	localparam int TV_W       = 14;
	localparam int OFF_W      = 27;
	localparam int DATA_W     = 64;
	localparam int LANE_SEL_W = 2;

	typedef struct packed {
		logic load;
		logic clear_h;
		logic mac;
		logic use_x;
		logic shift_acc;
		logic shift_h;
	} cell_ctl_t;

endpackage

[src/rnnc_cell.sv]
module rnnc_cell
	import rnnc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic signed [W_W-1:0]   bias,
	input  logic signed [W_W-1:0]   weight,
	input  logic signed [W_W-1:0]   x,
	input  logic signed [W_W-1:0]   h_next,
	input  logic signed [ACC_W-1:0] acc_next,
	output logic signed [W_W-1:0]   h,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [W_W-1:0]    h_q;
	logic signed [W_W-1:0]    opnd;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_q;

	assign opnd = ctl.use_x ? x : h_q;
	assign prod = PROD_W'(weight) * PROD_W'(opnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (ctl.load) begin
			if (ctl.clear_h) begin
				h_q <= '0;
			end
		end else if (ctl.mac && !ctl.use_x) begin
			h_q <= h_next;
		end else if (ctl.shift_h) begin
			h_q <= h_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= ACC_W'(bias) <<< FRAC_W;
		end else if (ctl.mac) begin
			acc_q <= acc_q + ACC_W'(prod);
		end else if (ctl.shift_acc) begin
			acc_q <= acc_next;
		end
	end

	assign h   = h_q;
	assign acc = acc_q;

endmodule

[src/rnnc_tanh.sv]
module rnnc_tanh
	import rnnc_pkg::*;
#(
	parameter int TANH_TABLE_DEPTH = 256
)
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    z_valid,
	input  logic signed [ACC_W-1:0] z,
	output logic                    t_valid,
	output logic signed [TV_W-1:0]  t
);

	localparam int IDX_W  = $clog2(TANH_TABLE_DEPTH);
	localparam int MUL_W  = OFF_W + $clog2(TANH_TABLE_DEPTH + 1);
	localparam int LUT_W  = TANH_TABLE_DEPTH * TV_W;
	localparam logic signed [ACC_W-1:0] ZLIM   = ACC_W'(64'sd1 <<< (OFF_W - 1));
	localparam logic signed [TV_W-1:0]  T_ONE  = TV_W'(1 << FRAC_W);

	function automatic logic [63:0] udiv64(
		input logic [63:0] dividend,
		input logic [63:0] divisor
	);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], dividend[b]};
			if (rem >= {1'b0, divisor}) begin
				rem    = rem - {1'b0, divisor};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [LUT_W-1:0] build_lut();
		logic [LUT_W-1:0] lut;
		logic [63:0]      mag_z;
		logic [63:0]      u;
		logic [63:0]      term;
		logic [63:0]      sum;
		logic [63:0]      e;
		logic [63:0]      num;
		logic [63:0]      den;
		logic [63:0]      mag;
		longint           zk;
		int               k;
		int               n;
		int               s;
		lut = '0;
		for (k = 0; k < TANH_TABLE_DEPTH; k++) begin
			zk = -64'sd16384 + longint'(udiv64(64'(k) * 64'd32768, 64'(TANH_TABLE_DEPTH)));
			mag_z = (zk < 0) ? 64'(-zk) : 64'(zk);
			u = mag_z << 15;
			term = 64'd1 << 30;
			sum = 64'd1 << 30;
			for (n = 1; n <= 25; n++) begin
				term = udiv64((term * u) >> 30, 64'(n));
				sum = sum + term;
			end
			e = udiv64((64'd1 << 60) + (sum >> 1), sum);
			for (s = 0; s < 4; s++) begin
				e = (e * e + (64'd1 << 29)) >> 30;
			end
			num = ((64'd1 << 30) - e) * 64'd4096;
			den = (64'd1 << 30) + e;
			mag = udiv64(num + (den >> 1), den);
			lut[k*TV_W +: TV_W] = (zk < 0) ? TV_W'(-mag) : TV_W'(mag);
		end
		return lut;
	endfunction

	localparam logic [LUT_W-1:0] LUT = build_lut();

	logic [ACC_W-1:0]        off_full;
	logic [MUL_W-1:0]        scaled;
	logic [IDX_W-1:0]        idx_s1;
	logic                    lo_s1;
	logic                    hi_s1;
	logic                    v_s1;
	logic signed [TV_W-1:0]  rom_s2;
	logic                    lo_s2;
	logic                    hi_s2;
	logic                    v_s2;

	assign off_full = z + ZLIM;
	assign scaled   = MUL_W'(off_full[OFF_W-1:0]) * MUL_W'(TANH_TABLE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= z_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		lo_s1  <= z < -ZLIM;
		hi_s1  <= z >= ZLIM;
		idx_s1 <= scaled[OFF_W +: IDX_W];
		rom_s2 <= LUT[idx_s1*TV_W +: TV_W];
		lo_s2  <= lo_s1;
		hi_s2  <= hi_s1;
	end

	assign t_valid = v_s2;
	assign t = lo_s2 ? -T_ONE : (hi_s2 ? T_ONE : rom_s2);

endmodule

[src/rnn_cell_inference.sv]
// Each input is taken only in the idle state and runs through the cell chain (one input and
// HIDDEN_UNITS recurrent products per cell), then the accumulators drain one at a time
// through the shared two-stage tanh table and the output multiply-accumulate; no new input
// is taken until the finish state has passed the result on, which waits while out_stall holds an earlier one.
// Reset clears the configuration registers, the hidden vector and all control state;
// there is no clearing pass and no item is held off after reset.
module rnn_cell_inference
	import rnnc_pkg::*;
#(
	parameter int HIDDEN_UNITS     = 4,
	parameter int TANH_TABLE_DEPTH = 256
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [15:0]    sample,
	input  logic                  seq_start,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [19:0]    prediction,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [5:0]            paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready
);

	localparam int PRED_W    = 20;
	localparam int YACC_W    = 36;
	localparam int YPROD_W   = W_W + TV_W;
	localparam int CNT_W     = $clog2(HIDDEN_UNITS + 2);
	localparam int LANE_W    = $clog2(HIDDEN_UNITS);
	localparam int REG_IDX_W = 3;
	localparam int NREGS     = 8;

	localparam logic [REG_IDX_W-1:0] REG_INPUT_W  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROW0     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BIAS     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_OUT_W    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_OUT_BIAS = 3'd7;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic signed [YACC_W-1:0] ROUND_HALF = YACC_W'(1 << (FRAC_W - 1));
	localparam logic signed [YACC_W-1:0] PRED_MAX   = YACC_W'((1 << (PRED_W - 1)) - 1);
	localparam logic signed [YACC_W-1:0] PRED_MIN   = -PRED_MAX - YACC_W'(1);

	function automatic logic signed [W_W-1:0] lane(
		input logic [DATA_W-1:0]     word,
		input logic [LANE_SEL_W-1:0] idx
	);
		return word[W_W*idx +: W_W];
	endfunction

	logic [DATA_W-1:0]         cfg_q [NREGS];
	logic [REG_IDX_W-1:0]      cfg_idx;
	logic [1:0]                state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [LANE_W-1:0]         ycnt_q;
	logic                      out_valid_q;
	logic signed [PRED_W-1:0]  prediction_q;
	logic signed [W_W-1:0]     sample_q;
	logic signed [YACC_W-1:0]  yacc_q;
	logic                      accept_in;
	logic                      issue;
	logic                      out_free;
	logic                      last_t;
	cell_ctl_t                 ctl;
	logic signed [W_W-1:0]     cell_h   [HIDDEN_UNITS];
	logic signed [ACC_W-1:0]   cell_acc [HIDDEN_UNITS];
	logic                      t_valid;
	logic signed [TV_W-1:0]    t_val;
	logic signed [YPROD_W-1:0] yprod;
	logic signed [YACC_W-1:0]  y_round;
	logic signed [YACC_W-1:0]  y_shift;
	logic signed [YACC_W-1:0]  y_sat;

	assign cfg_idx = paddr[5:3];
	assign pready  = 1'b1;
	assign prdata  = cfg_q[cfg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NREGS; r++) begin
				cfg_q[r] <= '0;
			end
		end else if (psel && penable && pwrite && pready) begin
			if (cfg_idx == REG_OUT_BIAS) begin
				cfg_q[cfg_idx] <= {{(DATA_W-W_W){1'b0}}, pwdata[W_W-1:0]};
			end else begin
				cfg_q[cfg_idx] <= pwdata;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign issue     = (state_q == ST_DRAIN) && (cnt_q < CNT_W'(HIDDEN_UNITS));
	assign out_free  = !out_valid_q || !out_stall;
	assign last_t    = t_valid && (ycnt_q == LANE_W'(HIDDEN_UNITS - 1));

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.load    = accept_in;
				ctl.clear_h = seq_start;
			end
			ST_MAC: begin
				ctl.mac   = 1'b1;
				ctl.use_x = (cnt_q == '0);
			end
			ST_DRAIN: begin
				ctl.shift_acc = issue;
				ctl.shift_h   = t_valid;
			end
			default: begin
			end
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < HIDDEN_UNITS; gi++) begin : g_cell
			logic [CNT_W:0]          src_sum;
			logic [LANE_W-1:0]       src;
			logic signed [W_W-1:0]   w_sel;
			logic signed [W_W-1:0]   h_in;
			logic signed [ACC_W-1:0] acc_in;

			assign src_sum = (CNT_W+1)'(gi) + {1'b0, cnt_q} - (CNT_W+1)'(1);
			assign src = (src_sum >= (CNT_W+1)'(HIDDEN_UNITS)) ?
				LANE_W'(src_sum - (CNT_W+1)'(HIDDEN_UNITS)) : LANE_W'(src_sum);
			assign w_sel = ctl.use_x ? lane(cfg_q[REG_INPUT_W], LANE_SEL_W'(gi)) :
				lane(cfg_q[REG_ROW0 + REG_IDX_W'(gi)], LANE_SEL_W'(src));

			if (gi == HIDDEN_UNITS - 1) begin : g_last
				assign h_in   = (state_q == ST_MAC) ? cell_h[0] : W_W'(t_val);
				assign acc_in = '0;
			end else begin : g_mid
				assign h_in   = cell_h[gi+1];
				assign acc_in = cell_acc[gi+1];
			end

			rnnc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.bias     (lane(cfg_q[REG_BIAS], LANE_SEL_W'(gi))),
				.weight   (w_sel),
				.x        (sample_q),
				.h_next   (h_in),
				.acc_next (acc_in),
				.h        (cell_h[gi]),
				.acc      (cell_acc[gi])
			);
		end
	endgenerate

	rnnc_tanh #(
		.TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
	) u_tanh (
		.clk     (clk),
		.arst_n  (arst_n),
		.z_valid (issue),
		.z       (cell_acc[0]),
		.t_valid (t_valid),
		.t       (t_val)
	);

	assign yprod   = YPROD_W'(lane(cfg_q[REG_OUT_W], LANE_SEL_W'(ycnt_q))) * YPROD_W'(t_val);
	assign y_round = yacc_q + ROUND_HALF;
	assign y_shift = y_round >>> FRAC_W;
	assign y_sat   = (y_shift > PRED_MAX) ? PRED_MAX :
		((y_shift < PRED_MIN) ? PRED_MIN : y_shift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ycnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						state_q <= ST_MAC;
						cnt_q   <= '0;
					end
				end
				ST_MAC: begin
					if (cnt_q == CNT_W'(HIDDEN_UNITS)) begin
						state_q <= ST_DRAIN;
						cnt_q   <= '0;
						ycnt_q  <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (t_valid) begin
						ycnt_q <= ycnt_q + LANE_W'(1);
					end
					if (last_t) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			sample_q <= sample;
			yacc_q   <= YACC_W'(lane(cfg_q[REG_OUT_BIAS], LANE_SEL_W'(0))) <<< FRAC_W;
		end else if (state_q == ST_DRAIN && t_valid) begin
			yacc_q <= yacc_q + YACC_W'(yprod);
		end
		if (state_q == ST_FIN && out_free) begin
			prediction_q <= y_sat[PRED_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign prediction = prediction_q;

endmodule

[src/rnnc_check.sv]
module rnnc_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [19:0] prediction
);

	// A waiting result must hold until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(prediction))
		else $error("prediction changed while stalled");

	// The chain works on one item at a time, so in_stall is held after each accepted input.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
		else $error("input taken again too early");

	// A new result only appears at the end of a step, never from the idle state.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a step in progress");

endmodule

bind rnn_cell_inference rnnc_check u_rnnc_check (.*);

[tb/sv/rnnc_tb_pkg.sv]
package rnnc_tb_pkg;

	localparam int UNITS       = 4;
	localparam int TABLE_DEPTH = 256;

	typedef enum int {
		REG_INPUT_WEIGHTS,
		REG_RECURRENT_ROW_0,
		REG_RECURRENT_ROW_1,
		REG_RECURRENT_ROW_2,
		REG_RECURRENT_ROW_3,
		REG_HIDDEN_BIASES,
		REG_OUTPUT_WEIGHTS,
		REG_OUTPUT_BIAS
	} cfg_reg_e;

	localparam int NUM_REGS = 8;

endpackage

[tb/sv/rnnc_checker.sv]
module rnnc_checker
	import rnnc_tb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] sample,
	input  logic               seq_start,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [19:0] prediction,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint Z_LIMIT = 64'sd4 << 24;

	logic [63:0] cell_cfg [NUM_REGS];
	int          hidden [UNITS];
	int          tanh_tab [TABLE_DEPTH];
	logic [19:0] predictions_due [$];

	function automatic int tanh_point(int zq);
		longint unsigned u, term, total, e, num, den, mag;
		u = longint'(zq < 0 ? -zq : zq) << 15;
		term = ONE_Q30;
		total = ONE_Q30;
		for (int n = 1; n <= 25; n++) begin
			term = ((term * u) >> 30) / n;
			total += term;
		end
		e = ((64'd1 << 60) + total / 2) / total;
		repeat (4) e = (e * e + (64'd1 << 29)) >> 30;
		num = (ONE_Q30 - e) * 4096;
		den = ONE_Q30 + e;
		mag = (num + den / 2) / den;
		return (zq < 0) ? -int'(mag) : int'(mag);
	endfunction

	function automatic longint lane_of(logic [63:0] word, int j);
		return longint'($signed(word[16*j +: 16]));
	endfunction

	function automatic int squash(longint z);
		if (z < -Z_LIMIT)
			return -4096;
		if (z >= Z_LIMIT)
			return 4096;
		return tanh_tab[int'(((z + Z_LIMIT) * TABLE_DEPTH) >> 27)];
	endfunction

	function automatic logic [19:0] advance_cell(logic [15:0] x, logic restart);
		longint acc, y;
		int fresh [UNITS];
		if (restart) begin
			for (int i = 0; i < UNITS; i++)
				hidden[i] = 0;
		end
		for (int i = 0; i < UNITS; i++) begin
			acc = lane_of(cell_cfg[REG_HIDDEN_BIASES], i) * 4096
				+ lane_of(cell_cfg[REG_INPUT_WEIGHTS], i) * longint'($signed(x));
			for (int j = 0; j < UNITS; j++)
				acc += lane_of(cell_cfg[REG_RECURRENT_ROW_0 + i], j) * hidden[j];
			fresh[i] = squash(acc);
		end
		hidden = fresh;
		acc = lane_of(cell_cfg[REG_OUTPUT_BIAS], 0) * 4096;
		for (int j = 0; j < UNITS; j++)
			acc += lane_of(cell_cfg[REG_OUTPUT_WEIGHTS], j) * hidden[j];
		y = (acc + 2048) >>> 12;
		if (y > 524287)
			y = 524287;
		if (y < -524288)
			y = -524288;
		return y[19:0];
	endfunction

	initial begin
		for (int k = 0; k < TABLE_DEPTH; k++)
			tanh_tab[k] = tanh_point(-16384 + int'((longint'(k) * 32768) / TABLE_DEPTH));
	end

	// When a transfer in and a transfer out share an edge, the older expectation is retired first.
	always @(posedge clk) begin
		int idx;
		logic [19:0] want;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
			for (int r = 0; r < NUM_REGS; r++)
				cell_cfg[r] = '0;
			for (int i = 0; i < UNITS; i++)
				hidden[i] = 0;
			predictions_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (predictions_due.size() == 0) begin
					if (errors < 10)
						$display("prediction %0d arrived with none expected", prediction);
					errors <= errors + 1;
				end else begin
					want = predictions_due.pop_front();
					if (prediction !== want) begin
						if (errors < 10)
							$display("prediction mismatch: expected %0d, got %0d",
								$signed(want), prediction);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				predictions_due.push_back(advance_cell(sample, seq_start));
			if (psel && penable && pwrite && pready) begin
				idx = int'(paddr[5:3]);
				cell_cfg[idx] = (idx == REG_OUTPUT_BIAS) ? {48'b0, pwdata[15:0]} : pwdata;
			end
			pending <= predictions_due.size();
		end
	end

endmodule

[tb/sv/tb_rnn_cell_inference.sv]
module tb_rnn_cell_inference;
	import rnnc_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] sample = '0;
	logic               seq_start = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [19:0] prediction;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [5:0]         paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;

	int          errors;
	int          pending;
	int          burst_left = 0;
	int          stall_mode = 0;
	int          stall_left = 0;
	logic [63:0] cfg_plan [NUM_REGS];

	rnn_cell_inference #(
		.HIDDEN_UNITS    (UNITS),
		.TANH_TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.seq_start (seq_start),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.prediction(prediction),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	rnnc_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.seq_start (seq_start),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.prediction(prediction),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.errors    (errors),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= 1'($urandom_range(0, 1));
			end
			2: begin
				out_stall <= ($urandom_range(0, 9) < 8);
			end
			default: begin
				out_stall <= (stall_left % 7 < 3);
			end
		endcase
	end

	initial begin
		#5_000_000;
		$display("rnn_cell_inference test failed");
		$finish;
	end

	function automatic logic [63:0] splat(logic [15:0] v);
		return {4{v}};
	endfunction

	function automatic logic [15:0] rand_lane(int style);
		case (style)
			1: begin
				return 16'($urandom_range(0, 6144) - 3072);
			end
			2: begin
				case ($urandom_range(0, 6))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'h0000;
					3: return 16'h0001;
					4: return 16'hFFFF;
					5: return 16'h0800;
					default: return 16'($urandom);
				endcase
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic feed(input logic [15:0] s, input logic st);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		sample <= s;
		seq_start <= st;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2 * UNITS + 12) @(posedge clk);
	endtask

	task automatic apply_cfg;
		for (int r = 0; r < NUM_REGS; r++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= 6'(r * 8);
			pwdata <= cfg_plan[r];
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int n_left;
		int run_len;
		int style;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		feed(16'h0000, 1'b1);
		feed(16'h7FFF, 1'b0);
		settle;

		for (int r = 0; r < NUM_REGS; r++)
			cfg_plan[r] = splat(16'h7FFF);
		apply_cfg;
		feed(16'h7FFF, 1'b1);
		feed(16'h8000, 1'b0);
		feed(16'h0000, 1'b0);
		feed(16'h8000, 1'b1);
		feed(16'hFFFF, 1'b0);
		feed(16'h0001, 1'b0);
		settle;

		for (int r = 0; r < NUM_REGS; r++)
			cfg_plan[r] = splat(16'h8000);
		apply_cfg;
		feed(16'h7FFF, 1'b1);
		feed(16'h8000, 1'b0);
		feed(16'h0000, 1'b1);
		feed(16'h7FFF, 1'b0);
		feed(16'h0001, 1'b0);
		settle;

		for (int r = 0; r < NUM_REGS; r++)
			cfg_plan[r] = '0;
		cfg_plan[REG_HIDDEN_BIASES] = {16'h3FFF, 16'hBFFF, 16'hC000, 16'h4000};
		cfg_plan[REG_OUTPUT_WEIGHTS] = {16'h0001, 16'hF800, 16'h0800, 16'h0800};
		apply_cfg;
		feed(16'h0000, 1'b1);
		feed(16'h7FFF, 1'b0);
		feed(16'h8000, 1'b1);
		settle;

		for (int r = 0; r < NUM_REGS; r++)
			cfg_plan[r] = '0;
		cfg_plan[REG_INPUT_WEIGHTS] = splat(16'h1000);
		cfg_plan[REG_OUTPUT_WEIGHTS] = splat(16'h1000);
		cfg_plan[REG_OUTPUT_BIAS] = 64'hFFFF_FFFF_FFFF_FFFF;
		apply_cfg;
		feed(16'h4000, 1'b1);
		feed(16'hC000, 1'b1);
		feed(16'hBFFF, 1'b1);
		feed(16'h3FFF, 1'b1);
		feed(16'h0800, 1'b0);

		for (int ph = 0; ph < 9; ph++) begin
			settle;
			style = ph % 3;
			for (int r = 0; r < NUM_REGS; r++)
				cfg_plan[r] = {rand_lane(style), rand_lane(style), rand_lane(style),
					rand_lane(style)};
			cfg_plan[REG_OUTPUT_BIAS] = {$urandom, $urandom};
			apply_cfg;
			n_left = 100;
			while (n_left > 0) begin
				run_len = $urandom_range(1, 16);
				for (int k = 0; k < run_len && n_left > 0; k++) begin
					feed(rand_lane($urandom_range(0, 3)),
						(k == 0) ^ ($urandom_range(0, 19) == 0));
					n_left--;
					if (ph == 4 && n_left == 50)
						settle;
				end
			end
		end
		settle;

		if (errors == 0)
			$display("rnn_cell_inference test passed");
		else
			$display("rnn_cell_inference test failed");
		$finish;
	end

endmodule

[files.f]
src/rnnc_pkg.sv
src/rnnc_cell.sv
src/rnnc_tanh.sv
src/rnn_cell_inference.sv
src/rnnc_check.sv
tb/sv/rnnc_tb_pkg.sv
tb/sv/rnnc_checker.sv
tb/sv/tb_rnn_cell_inference.sv
